// ----- sv/vibration_window_alarm_top_macros.svh -----
// ----------------------------------------------------------------------------
// vibration_window_alarm_top_macros
// Assertion macros shared by the alarm block RTL.
// ----------------------------------------------------------------------------
`ifndef VIBRATION_WINDOW_ALARM_TOP_MACROS_SVH
`define VIBRATION_WINDOW_ALARM_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define VWA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define VWA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/vwa_pkg.sv -----
// ----------------------------------------------------------------------------
// vwa_pkg
// Types and constants for the vibration window alarm.
// ----------------------------------------------------------------------------
package vwa_pkg;

  localparam int unsigned ACC_W   = 16;   // signed Q7.8 axis sample
  localparam int unsigned MAG_W   = 17;   // axis magnitude, holds 32768
  localparam int unsigned SUM_W   = 32;   // sum of squares
  localparam int unsigned ROOT_W  = 16;   // floor root, Q8.8
  localparam int unsigned REM_W   = 17;   // stored root remainder
  localparam int unsigned LVL_W   = 16;   // Q8.8 levels
  localparam int unsigned TRIG_W  = 5;
  localparam int unsigned CNT_O_W = 5;    // reported window count
  localparam int unsigned STEP_W  = 4;    // sequencer step counter
  localparam int unsigned IN_W    = 48;
  localparam int unsigned IN_U_W  = 2;
  localparam int unsigned OUT_W   = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [STEP_W-1:0] SQR_LAST  = 4'd2;
  localparam logic [STEP_W-1:0] ROOT_LAST = 4'd15;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CANCEL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_MAG   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIGGER   = 2'd3;

  localparam logic [LVL_W-1:0]  GRAVITY_RST   = 16'd2509;
  localparam logic [LVL_W-1:0]  THRESHOLD_RST = 16'd768;
  localparam logic [LVL_W-1:0]  MIN_MAG_RST   = 16'd256;
  localparam logic [TRIG_W-1:0] TRIGGER_RST   = 5'd8;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SQR    = 5'b00010,
    ST_ROOT   = 5'b00100,
    ST_EVAL   = 5'b01000,
    ST_UPDATE = 5'b10000
  } state_t;

endpackage

// ----- sv/vibration_window_alarm_top.sv -----
// Sample item: input transfer, then the squarer, root, evaluate and update states, then out_tvalid.
// Cancel item: idle goes straight to update. Either kind: a new item is taken only back in idle.
// The cost is set by one shared 17x17 squarer and a 2-bit-per-cycle root step.
// A waiting result does not block the next input transfer; only a full result register stalls.
// rst_n is synchronous, active low: window, count, alarm and peak clear, registers take defaults.
// ----------------------------------------------------------------------------
// vibration_window_alarm_top
// M-of-N shaking detector: magnitude by sequenced square and root, sliding
// flag window with running count, latched alarm and peak deviation.
// ----------------------------------------------------------------------------
`include "vibration_window_alarm_top_macros.svh"

module vibration_window_alarm_top
  import vwa_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32]
  input  logic [IN_W-1:0]       in_tdata,
  // tuser: opcode[0], sample_valid[1]
  input  logic [IN_U_W-1:0]     in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tdata: alarm[0], alarm_raised[1], shaking[2], discarded[3],
  //        window_count[8:4], peak_deviation[24:9], zero[31:25]
  output logic [OUT_W-1:0]      out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned PW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CXW   = CW + CNT_O_W;
  localparam logic [PW-1:0] POS_LAST = PW'(WINDOW_DEPTH - 1);

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;

  logic [LVL_W-1:0]    gravity_r, threshold_r, min_mag_r;
  logic [TRIG_W-1:0]   trigger_r;

  logic                op_r, svalid_r;
  logic [MAG_W-1:0]    mag_x_r, mag_y_r, mag_z_r;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [ROOT_W-1:0]   root_r, root_nxt;
  logic [LVL_W-1:0]    dev_r;
  logic                shake_r, discard_r;

  logic [WINDOW_DEPTH-1:0] flags_r;
  logic [PW-1:0]       pos_r;
  logic [CW-1:0]       total_r;
  logic                alarm_r;
  logic [LVL_W-1:0]    peak_r;

  logic [OUT_W-1:0]    out_data_r;
  logic                out_valid_r;

  logic                in_fire, upd_fire, out_free;
  logic [MAG_W-1:0]    sq_op;
  logic [2*MAG_W-1:0]  sq_full;
  logic [REM_W+1:0]    rem_shift, trial;
  logic [LVL_W:0]      diff;
  logic [LVL_W-1:0]    dev_c;
  logic                flag_old;
  logic [CW-1:0]       total_upd;
  logic                raise_c;
  logic [LVL_W-1:0]    peak_upd;
  logic [CXW-1:0]      total_ext;
  logic [CNT_O_W-1:0]  count_sat;
  logic [OUT_W-1:0]    result_c;

  function automatic logic [MAG_W-1:0] abs_acc(input logic [ACC_W-1:0] v);
    logic [MAG_W-1:0] w;
    w = {1'b0, v};
    return v[ACC_W-1] ? MAG_W'(({MAG_W{1'b0}} | 17'h10000) - w) : w;
  endfunction

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign upd_fire   = (state_r == ST_UPDATE) && out_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  // shared squarer, one axis per cycle
  always_comb begin
    case (step_r[1:0])
      2'd0:    sq_op = mag_x_r;
      2'd1:    sq_op = mag_y_r;
      2'd2:    sq_op = mag_z_r;
      default: sq_op = '0;
    endcase
    sq_full = sq_op * sq_op;
  end

  // root step: bring down two bits, try subtracting 4q+1
  always_comb begin
    rem_shift = {rem_r, sum_r[SUM_W-1 -: 2]};
    trial     = (REM_W + 2)'({root_r, 2'b01});
    if (rem_shift >= trial) begin
      rem_nxt  = REM_W'(rem_shift - trial);
      root_nxt = {root_r[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_shift[REM_W-1:0];
      root_nxt = {root_r[ROOT_W-2:0], 1'b0};
    end
  end

  always_comb begin
    sum_nxt = sum_r;
    case (state_r)
      ST_IDLE: sum_nxt = '0;
      ST_SQR:  sum_nxt = sum_r + sq_full[SUM_W-1:0];
      ST_ROOT: sum_nxt = {sum_r[SUM_W-3:0], 2'b00};
      default: sum_nxt = sum_r;
    endcase
  end

  assign diff  = {1'b0, root_r} - {1'b0, gravity_r};
  assign dev_c = diff[LVL_W] ? LVL_W'(~diff + 1'b1) : diff[LVL_W-1:0];

  // window commit
  always_comb begin
    flag_old  = flags_r[pos_r];
    total_upd = total_r;
    if (flag_old != shake_r) begin
      if (shake_r) begin
        total_upd = total_r + 1'b1;
      end else if (total_r != '0) begin
        total_upd = total_r - 1'b1;
      end
    end
    raise_c  = !alarm_r && (CXW'(total_upd) >= CXW'(trigger_r));
    peak_upd = (shake_r && dev_r > peak_r) ? dev_r : peak_r;
  end

  always_comb begin
    if (op_r == OP_CANCEL) begin
      total_ext = '0;
    end else if (discard_r) begin
      total_ext = CXW'(total_r);
    end else begin
      total_ext = CXW'(total_upd);
    end
    count_sat = (total_ext > CXW'(31)) ? CNT_O_W'(31) : total_ext[CNT_O_W-1:0];
    if (op_r == OP_CANCEL) begin
      result_c = '0;
    end else if (discard_r) begin
      result_c = OUT_W'({peak_r, count_sat, 1'b1, 1'b0, 1'b0, alarm_r});
    end else begin
      result_c = OUT_W'({peak_upd, count_sat, 1'b0, shake_r, raise_c,
                         alarm_r || raise_c});
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_fire) begin
          state_nxt = (in_tuser[0] == OP_CANCEL) ? ST_UPDATE : ST_SQR;
        end
      end
      ST_SQR: begin
        step_nxt = step_r + 1'b1;
        if (step_r == SQR_LAST) begin
          state_nxt = ST_ROOT;
          step_nxt  = '0;
        end
      end
      ST_ROOT: begin
        step_nxt = step_r + 1'b1;
        if (step_r == ROOT_LAST) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL:   state_nxt = ST_UPDATE;
      ST_UPDATE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      gravity_r   <= GRAVITY_RST;
      threshold_r <= THRESHOLD_RST;
      min_mag_r   <= MIN_MAG_RST;
      trigger_r   <= TRIGGER_RST;
      flags_r     <= '0;
      pos_r       <= '0;
      total_r     <= '0;
      alarm_r     <= 1'b0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRAVITY:   gravity_r   <= cfg_data;
          REG_THRESHOLD: threshold_r <= cfg_data;
          REG_MIN_MAG:   min_mag_r   <= cfg_data;
          REG_TRIGGER:   trigger_r   <= cfg_data[TRIG_W-1:0];
          default:       ;
        endcase
      end
      // a new result replaces the one leaving in the same cycle
      if (upd_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (upd_fire) begin
        if (op_r == OP_CANCEL) begin
          flags_r <= '0;
          total_r <= '0;
          alarm_r <= 1'b0;
          peak_r  <= '0;
        end else if (!discard_r) begin
          flags_r[pos_r] <= shake_r;
          total_r        <= total_upd;
          alarm_r        <= alarm_r || raise_c;
          peak_r         <= peak_upd;
          pos_r          <= (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    if (in_fire) begin
      op_r     <= in_tuser[0];
      svalid_r <= in_tuser[1];
      mag_x_r  <= abs_acc(in_tdata[15:0]);
      mag_y_r  <= abs_acc(in_tdata[31:16]);
      mag_z_r  <= abs_acc(in_tdata[47:32]);
    end
    if (state_r == ST_SQR) begin
      rem_r  <= '0;
      root_r <= '0;
    end else if (state_r == ST_ROOT) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
    if (state_r == ST_EVAL) begin
      dev_r     <= dev_c;
      discard_r <= !svalid_r || (root_r < min_mag_r);
      shake_r   <= svalid_r && (root_r >= min_mag_r) && (dev_c > threshold_r);
    end
    if (upd_fire) begin
      out_data_r <= result_c;
    end
  end

  `VWA_ASSERT_NOW(a_count_matches_flags, 1'b1, total_r == CW'($countones(flags_r)),
                  "window count out of step with flags")
  `VWA_ASSERT_NEXT(a_cancel_clears, upd_fire && op_r == OP_CANCEL,
                   total_r == '0 && !alarm_r && peak_r == '0, "cancel left state behind")
  `VWA_ASSERT_NEXT(a_peak_holds, upd_fire && op_r == OP_SAMPLE,
                   peak_r >= $past(peak_r), "peak fell without cancel")
  `VWA_ASSERT_NOW(a_raise_sets_alarm, out_valid_r && out_data_r[1],
                  out_data_r[0] && alarm_r, "raised result without latched alarm")

endmodule
